// ===== rtl/jpde_pkg.sv =====
// jpde_pkg: shared types, constants and saturating helpers for the jacobi
// polynomial derivative evaluator. No dependencies.
package jpde_pkg;

   // fixed-point formats
   localparam int FRAC_BITS = 32;
   localparam int X_FRAC    = 30;

   // recurrence index and coefficient widths (degree up to 63)
   localparam int KW   = 7;
   localparam int CW   = 22;
   localparam int DIVW = CW + FRAC_BITS + 1;
   localparam int DCW  = 6;

   // register indexes on the csr port
   localparam logic [1:0] REG_POLY_ORDER  = 2'd0;
   localparam logic [1:0] REG_DERIV_COUNT = 2'd1;
   localparam logic [1:0] REG_WEIGHT_EXP  = 2'd2;

   // one classified point with its configuration snapshot
   typedef struct packed {
      logic signed [31:0] point;
      logic [KW-1:0]      order;
      logic [2:0]         derivs;
      logic [2:0]         alpha;
   } job_type;

   // multiply unit command
   typedef struct packed {
      logic               start;
      logic               short_shift;
      logic signed [63:0] op_a;
      logic signed [63:0] op_b;
   } mul_cmd_type;

   // divide unit command
   typedef struct packed {
      logic            start;
      logic [DIVW-1:0] dividend;
      logic [CW-1:0]   divisor;
   } div_cmd_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

endpackage

// ===== rtl/jpde_front.sv =====
// jpde_front: csr registers, point classification and the job queue.
// Depends on jpde_pkg.
module jpde_front #(
   parameter int MAX_ORDER = 32,
   parameter int MAX_DERIV = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] point
   output logic              job_valid,
   input  logic              job_pop,
   output jpde_pkg::job_type job
);

   logic [5:0] poly_order_ff;
   logic [1:0] deriv_count_ff;
   logic [2:0] weight_exp_ff;

   jpde_pkg::job_type q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;
   jpde_pkg::job_type entry_in;

   assign csr_ready = 1'b1;

   // register writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_order_ff  <= '0;
         deriv_count_ff <= '0;
         weight_exp_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            jpde_pkg::REG_POLY_ORDER:  poly_order_ff  <= csr_data[5:0];
            jpde_pkg::REG_DERIV_COUNT: deriv_count_ff <= csr_data[1:0];
            jpde_pkg::REG_WEIGHT_EXP:  weight_exp_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // clamp degree and derivative count to the build limits
   always_comb begin
      entry_in.point = $signed(req_tdata);
      entry_in.order = ({1'b0, poly_order_ff} > jpde_pkg::KW'(MAX_ORDER))
                       ? jpde_pkg::KW'(MAX_ORDER) : {1'b0, poly_order_ff};
      entry_in.derivs = ({1'b0, deriv_count_ff} > 3'(MAX_DERIV))
                        ? 3'(MAX_DERIV) : {1'b0, deriv_count_ff};
      entry_in.alpha = weight_exp_ff;
   end

   // two-entry job queue
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign job_valid  = (count_ff != 2'd0);
   assign pop        = job_pop && job_valid;
   assign job        = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/jpde_mul.sv =====
// jpde_mul: shared 64x64 signed multiply with rounding shift and saturation,
// four 32x32 partial products over successive cycles. Depends on jpde_pkg.
module jpde_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  jpde_pkg::mul_cmd_type cmd,
   output logic                  done,
   output logic signed [63:0]    result
);

   typedef enum logic [1:0] {M_IDLE, M_PROD, M_ROUND, M_SAT} mstate_type;

   mstate_type     state_ff;
   logic           done_ff;
   logic           neg_ff, short_ff;
   logic [63:0]    ua_ff, ub_ff;
   logic [63:0]    pp_ff;
   logic [127:0]   acc_ff;
   logic [127:0]   q_ff;
   logic [2:0]     cnt_ff;
   logic signed [63:0] res_ff;

   logic [63:0]  pp_in;
   logic [127:0] pp_sh;
   logic [127:0] rnd_sum;
   logic [63:0]  limit, mag;

   // partial product select
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    pp_in = ua_ff[31:0]  * ub_ff[31:0];
         2'd1:    pp_in = ua_ff[31:0]  * ub_ff[63:32];
         2'd2:    pp_in = ua_ff[63:32] * ub_ff[31:0];
         default: pp_in = ua_ff[63:32] * ub_ff[63:32];
      endcase
      case (cnt_ff)
         3'd1:    pp_sh = 128'(pp_ff);
         3'd2:    pp_sh = 128'(pp_ff) << 32;
         3'd3:    pp_sh = 128'(pp_ff) << 32;
         default: pp_sh = 128'(pp_ff) << 64;
      endcase
   end

   // round half away from zero on the magnitude
   always_comb begin
      rnd_sum = short_ff ? acc_ff + (128'(1) << (jpde_pkg::X_FRAC - 1))
                         : acc_ff + (128'(1) << (jpde_pkg::FRAC_BITS - 1));
      limit   = neg_ff ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      mag     = (q_ff > {64'b0, limit}) ? limit : q_ff[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (cmd.start) begin
                  neg_ff   <= cmd.op_a[63] ^ cmd.op_b[63];
                  ua_ff    <= cmd.op_a[63] ? 64'(-cmd.op_a) : 64'(cmd.op_a);
                  ub_ff    <= cmd.op_b[63] ? 64'(-cmd.op_b) : 64'(cmd.op_b);
                  short_ff <= cmd.short_shift;
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= M_PROD;
               end
            end
            M_PROD: begin
               if (!cnt_ff[2]) pp_ff <= pp_in;
               if (cnt_ff != 3'd0) acc_ff <= acc_ff + pp_sh;
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd4) state_ff <= M_ROUND;
            end
            M_ROUND: begin
               q_ff     <= short_ff ? rnd_sum >> jpde_pkg::X_FRAC
                                    : rnd_sum >> jpde_pkg::FRAC_BITS;
               state_ff <= M_SAT;
            end
            M_SAT: begin
               res_ff   <= neg_ff ? $signed(-mag) : $signed(mag);
               done_ff  <= 1'b1;
               state_ff <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== rtl/jpde_div.sv =====
// jpde_div: bit-serial restoring divider for the recurrence coefficients,
// one quotient bit per cycle. Depends on jpde_pkg.
module jpde_div (
   input  logic                          clock,
   input  logic                          reset,
   input  jpde_pkg::div_cmd_type         cmd,
   output logic                          done,
   output logic [jpde_pkg::DIVW-1:0]     quot
);

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type                  state_ff;
   logic                        done_ff;
   logic [jpde_pkg::DIVW-1:0]   dvd_ff, q_ff;
   logic [jpde_pkg::CW-1:0]     den_ff, rem_ff;
   logic [jpde_pkg::DCW-1:0]    cnt_ff;
   logic [jpde_pkg::CW:0]       trial, diff;
   logic                        fits;

   // one restoring step
   always_comb begin
      trial = {rem_ff, dvd_ff[jpde_pkg::DIVW-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (cmd.start) begin
                  dvd_ff   <= cmd.dividend;
                  den_ff   <= cmd.divisor;
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= fits ? diff[jpde_pkg::CW-1:0] : trial[jpde_pkg::CW-1:0];
               q_ff   <= {q_ff[jpde_pkg::DIVW-2:0], fits};
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == jpde_pkg::DCW'(jpde_pkg::DIVW - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== rtl/jpde_back.sv =====
// jpde_back: recurrence sequencer, derivative rows and result register.
// Depends on jpde_pkg; drives the shared jpde_mul and jpde_div units.
module jpde_back #(
   parameter int MAX_DERIV = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_pop,
   input  jpde_pkg::job_type            job,
   output jpde_pkg::mul_cmd_type        mul_cmd,
   input  logic                         mul_done,
   input  logic signed [63:0]           mul_res,
   output jpde_pkg::div_cmd_type        div_cmd,
   input  logic                         div_done,
   input  logic [jpde_pkg::DIVW-1:0]    div_quot,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [63:0]                  rsp_tdata,   // [63:0] value
   output logic [1:0]                   rsp_tuser,   // [1:0] deriv_order
   output logic                         rsp_tlast
);

   localparam int ROWS = MAX_DERIV + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_COEF1, S_COEF2, S_DIV2, S_DIV3, S_DIV4, S_MULM,
      S_ROW_A, S_ROW_B, S_ROW_C, S_SHIFT, S_EMIT
   } state_type;

   state_type                    state_ff;
   logic                         issued_ff;
   logic signed [31:0]           x_ff;
   logic [jpde_pkg::KW-1:0]      n_ff, k_ff;
   logic [2:0]                   d_ff, a_ff, i_ff, e_ff;
   logic [15:0]                  ra_ff, rb_ff, rc_ff, rd_ff;
   logic [jpde_pkg::CW-1:0]      c1_ff, num2_ff, num4_ff;
   logic signed [63:0]           a2_ff, a3_ff, a4_ff, m_ff, v_ff, hold_ff;
   logic signed [63:0]           cur_ff  [ROWS];
   logic signed [63:0]           prev_ff [ROWS];
   logic                         rsp_tvalid_ff, rsp_tlast_ff;
   logic [1:0]                   rsp_tuser_ff;
   logic [63:0]                  rsp_tdata_ff;

   logic [7:0]          twok, ka, sk;
   logic [15:0]         ra_in, rb_in, rc_in, rd_in;
   logic [23:0]         c1_in, num2_in, num4_in;
   logic [3:0]          ap2;
   logic signed [36:0]  tx;
   logic signed [63:0]  t0, r0_in, r1_in, one_val, a3i;
   logic                wait_state;

   // small integer factors of the coefficients
   always_comb begin
      twok    = {k_ff, 1'b0};
      ka      = 8'(k_ff) + 8'(a_ff);
      sk      = twok + 8'(a_ff);
      ra_in   = 16'(twok) * 16'(ka);
      rb_in   = 16'(sk - 8'd1) * 16'(sk);
      rc_in   = 16'(sk - 8'd1) * 16'(a_ff);
      rd_in   = {15'(16'(ka - 8'd1) * 16'(8'(k_ff) - 8'd1)), 1'b0};
      c1_in   = 24'(ra_ff) * 24'(sk - 8'd2);
      num2_in = 24'(rc_ff) * 24'(a_ff);
      num4_in = 24'(rd_ff) * 24'(sk);
   end

   // start rows for degree one
   always_comb begin
      ap2     = {1'b0, job.alpha} + 4'd2;
      tx      = job.point * $signed({1'b0, ap2});
      t0      = 64'(tx) + 64'({job.alpha, {jpde_pkg::X_FRAC{1'b0}}});
      r0_in   = t0 <<< 1;
      r1_in   = $signed(64'(ap2) << (jpde_pkg::FRAC_BITS - 1));
      one_val = $signed(64'(1) << jpde_pkg::FRAC_BITS);
   end

   // a3 times the row index, by shift and add
   always_comb begin
      a3i = (i_ff[0] ? a3_ff : 64'sd0)
          + (i_ff[1] ? (a3_ff <<< 1) : 64'sd0)
          + (i_ff[2] ? (a3_ff <<< 2) : 64'sd0);
   end

   // unit commands, issued once on entry to a wait state
   always_comb begin
      div_cmd.start    = 1'b0;
      div_cmd.dividend = '0;
      div_cmd.divisor  = c1_ff;
      mul_cmd.start       = 1'b0;
      mul_cmd.short_shift = 1'b0;
      mul_cmd.op_a        = cur_ff[0];
      mul_cmd.op_b        = m_ff;
      case (state_ff)
         S_DIV2: begin
            div_cmd.start    = !issued_ff;
            div_cmd.dividend = jpde_pkg::DIVW'({num2_ff, {jpde_pkg::FRAC_BITS{1'b0}}})
                             + jpde_pkg::DIVW'(c1_ff >> 1);
         end
         S_DIV3: begin
            div_cmd.start    = !issued_ff;
            div_cmd.divisor  = jpde_pkg::CW'(ra_ff);
            div_cmd.dividend = jpde_pkg::DIVW'({rb_ff, {jpde_pkg::FRAC_BITS{1'b0}}})
                             + jpde_pkg::DIVW'(ra_ff >> 1);
         end
         S_DIV4: begin
            div_cmd.start    = !issued_ff;
            div_cmd.dividend = jpde_pkg::DIVW'({num4_ff, {jpde_pkg::FRAC_BITS{1'b0}}})
                             + jpde_pkg::DIVW'(c1_ff >> 1);
         end
         S_MULM: begin
            mul_cmd.start       = !issued_ff;
            mul_cmd.short_shift = 1'b1;
            mul_cmd.op_a        = 64'(x_ff);
            mul_cmd.op_b        = a3_ff;
         end
         S_ROW_A: mul_cmd.start = !issued_ff;
         S_ROW_B: begin
            mul_cmd.start = !issued_ff;
            mul_cmd.op_a  = prev_ff[0];
            mul_cmd.op_b  = a4_ff;
         end
         S_ROW_C: begin
            mul_cmd.start = !issued_ff && (i_ff != 3'd0);
            mul_cmd.op_a  = hold_ff;
            mul_cmd.op_b  = a3i;
         end
         default: ;
      endcase
   end

   // row zero passes through S_ROW_C without a product
   assign wait_state = (state_ff == S_DIV2) || (state_ff == S_DIV3) ||
                       (state_ff == S_DIV4) || (state_ff == S_MULM) ||
                       (state_ff == S_ROW_A) || (state_ff == S_ROW_B) ||
                       ((state_ff == S_ROW_C) && (i_ff != 3'd0));
   assign job_pop = (state_ff == S_IDLE) && job_valid;

   // sequencer, rows and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issued_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (wait_state && !issued_ff) issued_ff <= 1'b1;
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_EMIT)) rsp_tvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  x_ff <= job.point;
                  n_ff <= job.order;
                  d_ff <= job.derivs;
                  a_ff <= job.alpha;
                  k_ff <= jpde_pkg::KW'(2);
                  i_ff <= '0;
                  e_ff <= '0;
                  for (int j = 0; j < ROWS; j++) begin
                     if (j == 0) begin
                        cur_ff[j]  <= (job.order != '0) ? r0_in : one_val;
                        prev_ff[j] <= (job.order != '0) ? one_val : 64'sd0;
                     end else if (j == 1) begin
                        cur_ff[j]  <= (job.order != '0) ? r1_in : 64'sd0;
                        prev_ff[j] <= 64'sd0;
                     end else begin
                        cur_ff[j]  <= 64'sd0;
                        prev_ff[j] <= 64'sd0;
                     end
                  end
                  state_ff <= (job.order > jpde_pkg::KW'(1)) ? S_COEF1 : S_EMIT;
               end
            end
            S_COEF1: begin
               ra_ff    <= ra_in;
               rb_ff    <= rb_in;
               rc_ff    <= rc_in;
               rd_ff    <= rd_in;
               state_ff <= S_COEF2;
            end
            S_COEF2: begin
               c1_ff    <= c1_in[jpde_pkg::CW-1:0];
               num2_ff  <= num2_in[jpde_pkg::CW-1:0];
               num4_ff  <= num4_in[jpde_pkg::CW-1:0];
               state_ff <= S_DIV2;
            end
            S_DIV2: if (div_done) begin
               a2_ff     <= $signed(64'(div_quot));
               issued_ff <= 1'b0;
               state_ff  <= S_DIV3;
            end
            S_DIV3: if (div_done) begin
               a3_ff     <= $signed(64'(div_quot));
               issued_ff <= 1'b0;
               state_ff  <= S_DIV4;
            end
            S_DIV4: if (div_done) begin
               a4_ff     <= $signed(64'(div_quot));
               issued_ff <= 1'b0;
               state_ff  <= S_MULM;
            end
            S_MULM: if (mul_done) begin
               m_ff      <= jpde_pkg::sat_add(mul_res, a2_ff);
               issued_ff <= 1'b0;
               state_ff  <= S_ROW_A;
            end
            S_ROW_A: if (mul_done) begin
               v_ff      <= mul_res;
               issued_ff <= 1'b0;
               state_ff  <= S_ROW_B;
            end
            S_ROW_B: if (mul_done) begin
               v_ff      <= jpde_pkg::sat_sub(v_ff, mul_res);
               issued_ff <= 1'b0;
               state_ff  <= S_ROW_C;
            end
            S_ROW_C: begin
               // row zero has no lower-order term
               if (i_ff == 3'd0) begin
                  state_ff  <= S_SHIFT;
               end else if (mul_done) begin
                  v_ff      <= jpde_pkg::sat_add(v_ff, mul_res);
                  issued_ff <= 1'b0;
                  state_ff  <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               // rotate rows: new value in at the tail, old row to previous
               for (int j = 0; j < ROWS - 1; j++) begin
                  cur_ff[j]  <= cur_ff[j+1];
                  prev_ff[j] <= prev_ff[j+1];
               end
               cur_ff[ROWS-1]  <= v_ff;
               prev_ff[ROWS-1] <= cur_ff[0];
               hold_ff         <= cur_ff[0];
               if (i_ff == 3'(ROWS - 1)) begin
                  i_ff <= '0;
                  if (k_ff == n_ff) begin
                     e_ff     <= '0;
                     state_ff <= S_EMIT;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_COEF1;
                  end
               end else begin
                  i_ff     <= i_ff + 3'd1;
                  state_ff <= S_ROW_A;
               end
            end
            S_EMIT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= cur_ff[0];
                  rsp_tuser_ff  <= e_ff[1:0];
                  rsp_tlast_ff  <= (e_ff == d_ff);
                  for (int j = 0; j < ROWS - 1; j++) cur_ff[j] <= cur_ff[j+1];
                  cur_ff[ROWS-1] <= cur_ff[0];
                  e_ff <= e_ff + 3'd1;
                  if (e_ff == d_ff) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ===== rtl/jacobi_poly_deriv_eval.sv =====
// Each req point yields rsp words for derivative orders 0..d, one rsp word per cycle
// while rsp_tready is high; a stall holds the word in the rsp register.
// Each recurrence step k runs setup in S_COEF1 and S_COEF2, three bit-serial divisions
// and three products per row on the shared multiplier (row zero has no lower-order
// product), plus one rotate in S_SHIFT per row.
// One point is worked at a time; a two-word queue and the rsp register decouple.
// Reset (synchronous, active high) clears registers, queue and sequencer.
module jacobi_poly_deriv_eval #(
   parameter int MAX_ORDER = 32,
   parameter int MAX_DERIV = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic [1:0]  rsp_tuser,   // [1:0] deriv_order
   output logic        rsp_tlast
);

   logic                           job_valid, job_pop;
   jpde_pkg::job_type              job;
   jpde_pkg::mul_cmd_type          mul_cmd;
   jpde_pkg::div_cmd_type          div_cmd;
   logic                           mul_done, div_done;
   logic signed [63:0]             mul_res;
   logic [jpde_pkg::DIVW-1:0]      div_quot;

   jpde_front #(.MAX_ORDER(MAX_ORDER), .MAX_DERIV(MAX_DERIV)) u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .job_valid(job_valid), .job_pop(job_pop), .job(job)
   );

   jpde_mul u_mul (
      .clock(clock), .reset(reset), .cmd(mul_cmd), .done(mul_done), .result(mul_res)
   );

   jpde_div u_div (
      .clock(clock), .reset(reset), .cmd(div_cmd), .done(div_done), .quot(div_quot)
   );

   jpde_back #(.MAX_DERIV(MAX_DERIV)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_pop(job_pop), .job(job),
      .mul_cmd(mul_cmd), .mul_done(mul_done), .mul_res(mul_res),
      .div_cmd(div_cmd), .div_done(div_done), .div_quot(div_quot),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

endmodule

// ===== rtl/jpde_checker.sv =====
// jpde_checker: port-level assertions on the result stream, bound to the
// top level jacobi_poly_deriv_eval. No package dependency.
module jpde_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic [1:0] exp_ff;

   // expected derivative order of the next rsp word
   always_ff @(posedge clock) begin
      if (reset) exp_ff <= '0;
      else if (rsp_tvalid && rsp_tready) exp_ff <= rsp_tlast ? 2'd0 : exp_ff + 2'd1;
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_order_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> rsp_tuser == exp_ff)
      else $error("derivative orders out of sequence");

endmodule

bind jacobi_poly_deriv_eval jpde_checker u_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
